// ----- src/ksm_pkg.sv -----
package ksm_pkg;

  localparam int MAX_WAYS     = 16;
  localparam int STREAM_SLOTS = 16;
  localparam int ACTIVE_MAX   = (MAX_WAYS < STREAM_SLOTS) ? MAX_WAYS : STREAM_SLOTS;

  localparam int IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int STREAM_W = 4;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = 5;
  localparam int WAYS_W   = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(16);

  typedef enum logic [0:0] {
    REG_WAYS_IN_USE = 1'b0
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Clamp the programmed way count: zero acts as one, large values saturate.
  function automatic logic [CNT_W-1:0] active_ways(input logic [WAYS_W-1:0] w);
    logic [CNT_W-1:0] r;
    r = CNT_W'(w);
    if (w == '0) r = CNT_W'(1);
    if (CNT_W'(w) > CNT_W'(ACTIVE_MAX)) r = CNT_W'(ACTIVE_MAX);
    return r;
  endfunction

endpackage

// ----- src/kway_sorted_stream_merger_unit.sv -----
// Result: a request that completes the fill or delivers the awaited refill yields its result
//   after a scan that passes each stored head in turn through the shared comparator and
//   a step that loads the output register; other requests yield no result.
// Requests: while merging, no new request is taken until the scan and the load are through;
//   a stalled output register holds the unit in that load step.
// Reset: synchronous, active low; clears valid bits, fill count, refill/finish flags,
//   sets ways_in_use to 16. Head values are not reset.
module kway_sorted_stream_merger_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ksm_pkg::STREAM_W-1:0]    in_stream_index,
  input  logic signed [ksm_pkg::VALUE_W-1:0] in_element_value,
  input  logic                            in_stream_ended,
  // merged results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [ksm_pkg::VALUE_W-1:0] out_merged_value,
  output logic [ksm_pkg::STREAM_W-1:0]    out_refill_stream,
  output logic                            out_all_done,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [ksm_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [ksm_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [ksm_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import ksm_pkg::*;

  // Sequencer and merge control state.
  state_t                     state_r, state_nxt;
  logic [WAYS_W-1:0]          ways_r;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic                       awaiting_r, awaiting_nxt;
  logic                       finished_r, finished_nxt;
  logic [STREAM_W-1:0]        awaited_r, awaited_nxt;

  // Head store: one 32-bit value and a valid bit per stream.
  logic signed [VALUE_W-1:0]  head_val_r [MAX_WAYS];
  logic [MAX_WAYS-1:0]        head_vld_r;

  // Scan datapath around the shared comparator.
  logic [CNT_W-1:0]           scan_r, scan_nxt;
  logic                       found_r, found_nxt;
  logic [IDX_W-1:0]           best_idx_r, best_idx_nxt;
  logic signed [VALUE_W-1:0]  best_val_r, best_val_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0]  out_val_r, out_val_nxt;
  logic [STREAM_W-1:0]        out_stream_r, out_stream_nxt;
  logic                       out_done_r, out_done_nxt;

  logic [CNT_W-1:0]           ways;
  logic                       in_acc;
  logic                       take_refill;
  logic                       take_fill;
  logic                       head_wr;
  logic [CNT_W-1:0]           fill_inc;
  logic                       scan_go;
  logic                       scan_last;
  logic                       out_free;
  logic signed [VALUE_W-1:0]  scan_val;
  logic                       scan_vld;
  logic                       cfg_wr;

  // ---------------------------------------------------------------------
  // Configuration port: zero-wait APB, one register.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == REG_WAYS_IN_USE);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_WAYS_IN_USE) begin
      cfg_prdata = CFG_DW'(ways_r);
    end
  end

  // ---------------------------------------------------------------------
  // Request decode. Requests are taken only in idle; a request is either
  // dropped, a fill of one head, or the awaited refill.
  // ---------------------------------------------------------------------
  assign ways     = active_ways(ways_r);
  assign in_acc   = in_valid && !in_stall;
  assign fill_inc = (fill_r < CNT_W'(STREAM_SLOTS)) ? (fill_r + CNT_W'(1)) : fill_r;

  always_comb begin
    take_refill = 1'b0;
    take_fill   = 1'b0;
    if (!finished_r) begin
      if (awaiting_r) begin
        take_refill = (in_stream_index == awaited_r);
      end else begin
        take_fill = (CNT_W'(in_stream_index) < ways);
      end
    end
  end

  assign head_wr = in_acc && (take_refill || take_fill);
  // The request that completes the fill, or the refill, starts a scan.
  assign scan_go = take_refill || (take_fill && (fill_inc >= ways));

  // Shared comparator: one stored head against the running minimum per cycle.
  assign scan_val  = head_val_r[IDX_W'(scan_r)];
  assign scan_vld  = head_vld_r[IDX_W'(scan_r)];
  assign scan_last = (scan_r == (ways - CNT_W'(1)));
  assign out_free  = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------
  // Next state.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && scan_go) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_EMIT;
      ST_EMIT: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Outputs and datapath next values.
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    fill_nxt       = fill_r;
    awaiting_nxt   = awaiting_r;
    finished_nxt   = finished_r;
    awaited_nxt    = awaited_r;
    scan_nxt       = scan_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_val_nxt   = best_val_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_val_nxt    = out_val_r;
    out_stream_nxt = out_stream_r;
    out_done_nxt   = out_done_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && take_fill) fill_nxt = fill_inc;
        // Arm the scan from the first stream.
        scan_nxt  = '0;
        found_nxt = 1'b0;
      end
      ST_SCAN: begin
        // Strict less-than keeps the lowest stream on ties.
        if (scan_vld && (!found_r || (scan_val < best_val_r))) begin
          found_nxt    = 1'b1;
          best_idx_nxt = IDX_W'(scan_r);
          best_val_nxt = scan_val;
        end
        scan_nxt = scan_r + CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_val_nxt    = best_val_r;
            out_stream_nxt = STREAM_W'(best_idx_r);
            out_done_nxt   = 1'b0;
            awaiting_nxt   = 1'b1;
            awaited_nxt    = STREAM_W'(best_idx_r);
          end else begin
            // No valid head left: report done and ignore everything after.
            out_val_nxt    = '0;
            out_stream_nxt = '0;
            out_done_nxt   = 1'b1;
            awaiting_nxt   = 1'b0;
            finished_nxt   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ways_r      <= WAYS_RESET;
      fill_r      <= '0;
      awaiting_r  <= 1'b0;
      finished_r  <= 1'b0;
      awaited_r   <= '0;
      head_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      awaiting_r  <= awaiting_nxt;
      finished_r  <= finished_nxt;
      awaited_r   <= awaited_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) ways_r <= cfg_pwdata[WAYS_W-1:0];
      // An end mark drops the head; a value loads it.
      if (head_wr) head_vld_r[IDX_W'(in_stream_index)] <= !in_stream_ended;
    end
  end

  always_ff @(posedge clk) begin
    if (head_wr && !in_stream_ended) begin
      head_val_r[IDX_W'(in_stream_index)] <= in_element_value;
    end
    scan_r       <= scan_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_val_r   <= best_val_nxt;
    out_val_r    <= out_val_nxt;
    out_stream_r <= out_stream_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_merged_value  = out_val_r;
  assign out_refill_stream = out_stream_r;
  assign out_all_done      = out_done_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_finished_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r |=> finished_r)
    else $error("finished flag dropped without reset");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(finished_r && awaiting_r))
    else $error("awaiting refill while finished");

  a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> finished_r)
    else $error("done result without finished state");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit step");

endmodule
